// File: rtl/core/mcmp_pkg.sv
// ----------------------------------------------------------------------------
// mcmp_pkg
// Shared types and constants for the MIDI channel message parser.
// ----------------------------------------------------------------------------
package mcmp_pkg;

   localparam int unsigned ByteWidth     = 8;
   localparam int unsigned DataWidth     = 7;
   localparam int unsigned ChanWidth     = 4;
   localparam int unsigned KindWidth     = 2;
   localparam int unsigned WheelWidth    = 16;
   localparam int unsigned RspDataWidth  = KindWidth + 2 * DataWidth + WheelWidth;
   localparam int unsigned QueueDepthDef = 2;

   localparam logic [3:0] NibbleSystem = 4'hF;
   localparam logic [3:0] NibbleNoteOff = 4'h8;
   localparam logic [3:0] NibbleNoteOn  = 4'h9;
   localparam logic [3:0] NibblePoly    = 4'hA;
   localparam logic [3:0] NibbleCtrl    = 4'hB;
   localparam logic [3:0] NibbleProg    = 4'hC;
   localparam logic [3:0] NibbleChPress = 4'hD;
   localparam logic [3:0] NibbleWheel   = 4'hE;
   localparam logic [7:0] ByteSysexStart = 8'hF0;
   localparam logic [7:0] ByteSysexEnd   = 8'hF7;

   typedef enum logic [1:0] {
      PH_IDLE   = 2'd0,
      PH_FIRST  = 2'd1,
      PH_SECOND = 2'd2,
      PH_SYSEX  = 2'd3
   } phase_type;

   typedef enum logic [3:0] {
      CLS_NONE,
      CLS_NOTE_OFF,
      CLS_NOTE_ON,
      CLS_POLY,
      CLS_CTRL,
      CLS_PROG,
      CLS_CHPRESS,
      CLS_WHEEL,
      CLS_SYSEX_START,
      CLS_SYSEX_END
   } class_type;

   typedef enum logic [KindWidth-1:0] {
      EV_NONE  = 2'd0,
      EV_ON    = 2'd1,
      EV_OFF   = 2'd2,
      EV_WHEEL = 2'd3
   } event_type;

   typedef struct packed {
      event_type            kind;
      logic [DataWidth-1:0] d1;
      logic [DataWidth-1:0] d2;
   } entry_type;

endpackage

// File: rtl/core/mcmp_front.sv
// ----------------------------------------------------------------------------
// mcmp_front
// Running-status tracker: classifies each byte and queues one event entry.
// ----------------------------------------------------------------------------
module mcmp_front
   import mcmp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic [ChanWidth-1:0] listen_channel,
   input  logic                 accept,
   input  logic [ByteWidth-1:0] midi_byte,
   output entry_type            entry
);

   phase_type            phase_ff,   phase_in;
   class_type            class_ff,   class_in;
   logic [ChanWidth-1:0] chan_ff,    chan_in;
   logic [DataWidth-1:0] first_ff,   first_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         class_ff <= CLS_NONE;
         chan_ff  <= '0;
         first_ff <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         class_ff <= class_in;
         chan_ff  <= chan_in;
         first_ff <= first_in;
      end
   end

   always_comb begin
      logic [DataWidth-1:0] data;
      data     = midi_byte[DataWidth-1:0];
      phase_in = phase_ff;
      class_in = class_ff;
      chan_in  = chan_ff;
      first_in = first_ff;
      entry    = '{kind: EV_NONE, d1: '0, d2: '0};
      if (midi_byte[7]) begin
         if (midi_byte[7:4] != NibbleSystem) begin
            chan_in  = midi_byte[3:0];
            phase_in = PH_FIRST;
            unique case (midi_byte[6:4])
               NibbleNoteOff[2:0]: class_in = CLS_NOTE_OFF;
               NibbleNoteOn[2:0]:  class_in = CLS_NOTE_ON;
               NibblePoly[2:0]:    class_in = CLS_POLY;
               NibbleCtrl[2:0]:    class_in = CLS_CTRL;
               NibbleProg[2:0]:    class_in = CLS_PROG;
               NibbleChPress[2:0]: class_in = CLS_CHPRESS;
               NibbleWheel[2:0]:   class_in = CLS_WHEEL;
               default:            class_in = CLS_NONE;
            endcase
         end else if (midi_byte == ByteSysexStart) begin
            class_in = CLS_SYSEX_START;
            phase_in = PH_SYSEX;
         end else if (midi_byte == ByteSysexEnd) begin
            class_in = CLS_SYSEX_END;
            phase_in = PH_IDLE;
         end
      end else begin
         unique case (class_ff)
            CLS_NOTE_OFF, CLS_NOTE_ON, CLS_WHEEL: begin
               if (phase_ff == PH_FIRST) begin
                  first_in = data;
                  phase_in = PH_SECOND;
               end else if (phase_ff == PH_SECOND) begin
                  phase_in = PH_FIRST;
                  if (class_ff == CLS_WHEEL) begin
                     entry = '{kind: EV_WHEEL, d1: first_ff, d2: data};
                  end else if (chan_ff == listen_channel) begin
                     entry.kind = (class_ff == CLS_NOTE_ON && data != '0) ? EV_ON : EV_OFF;
                     entry.d1   = first_ff;
                     entry.d2   = data;
                  end
               end
            end
            CLS_POLY, CLS_CTRL: begin
               if (phase_ff == PH_FIRST) begin
                  phase_in = PH_SECOND;
               end else if (phase_ff == PH_SECOND) begin
                  phase_in = PH_FIRST;
               end
            end
            CLS_PROG: phase_in = PH_FIRST;
            default: ;
         endcase
      end
   end

   a_event_from_second: assert property (@(posedge clock) disable iff (reset)
      (accept && entry.kind != EV_NONE) |-> (phase_ff == PH_SECOND && !midi_byte[7]))
      else $error("event emitted outside second data byte");

   a_second_after_first: assert property (@(posedge clock) disable iff (reset)
      (accept && !midi_byte[7] && phase_ff == PH_FIRST &&
       (class_ff == CLS_NOTE_ON || class_ff == CLS_WHEEL)) |=> phase_ff == PH_SECOND)
      else $error("phase did not advance on first data byte");

   a_status_sets_first: assert property (@(posedge clock) disable iff (reset)
      (accept && midi_byte[7] && midi_byte[7:4] != NibbleSystem) |=> phase_ff == PH_FIRST)
      else $error("channel status did not restart data phase");

endmodule

// File: rtl/core/mcmp_queue.sv
// ----------------------------------------------------------------------------
// mcmp_queue
// Small FIFO of event entries between the tracker and the output stage.
// ----------------------------------------------------------------------------
module mcmp_queue
   import mcmp_pkg::*;
#(
   parameter int unsigned DEPTH = QueueDepthDef
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_data,
   output logic      full,
   input  logic      pop,
   output logic      not_empty,
   output entry_type pop_data
);

   localparam int unsigned PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CntWidth = $clog2(DEPTH + 1);
   localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(DEPTH - 1);
   localparam logic [CntWidth-1:0] DepthCnt = CntWidth'(DEPTH);

   entry_type            mem_ff [DEPTH];
   logic [PtrWidth-1:0]  wr_ff, wr_in;
   logic [PtrWidth-1:0]  rd_ff, rd_in;
   logic [CntWidth-1:0]  cnt_ff, cnt_in;

   assign full      = (cnt_ff == DepthCnt);
   assign not_empty = (cnt_ff != '0);
   assign pop_data  = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == LastPtr) ? '0 : wr_ff + PtrWidth'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == LastPtr) ? '0 : rd_ff + PtrWidth'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + CntWidth'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CntWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("pop from empty queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= DepthCnt)
      else $error("queue count beyond depth");

endmodule

// File: rtl/core/mcmp_back.sv
// ----------------------------------------------------------------------------
// mcmp_back
// Output stage: formats queued entries into result beats and holds them.
// ----------------------------------------------------------------------------
module mcmp_back
   import mcmp_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_not_empty,
   input  entry_type               q_data,
   output logic                    q_pop,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [RspDataWidth-1:0] rsp_tdata
);

   logic                    valid_ff, valid_in;
   logic [RspDataWidth-1:0] data_ff,  data_in;

   assign q_pop      = q_not_empty && (!valid_ff || rsp_tready);
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

   always_comb begin
      logic [DataWidth-1:0]  note;
      logic [DataWidth-1:0]  vel;
      logic [WheelWidth-1:0] wheel;
      note  = '0;
      vel   = '0;
      wheel = '0;
      unique case (q_data.kind)
         EV_ON, EV_OFF: begin
            note = q_data.d1;
            vel  = q_data.d2;
         end
         EV_WHEEL: wheel = {q_data.d2, q_data.d1, 2'b00};
         default: ;
      endcase
      data_in  = {wheel, vel, note, q_data.kind};
      valid_in = q_pop || (valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         data_ff <= data_in;
      end
   end

   a_no_pop_while_stalled: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !rsp_tready) |-> !q_pop)
      else $error("output overwritten while stalled");

   a_pop_loads_beat: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> valid_ff)
      else $error("popped entry not presented");

   a_wheel_clean: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && data_ff[KindWidth-1:0] != EV_WHEEL) |-> data_ff[RspDataWidth-1 -: WheelWidth] == '0)
      else $error("wheel field set on non-wheel beat");

endmodule

// File: rtl/core/midi_channel_message_parser.sv
// ----------------------------------------------------------------------------
// midi_channel_message_parser
// MIDI byte stream parser with running status; reports note and wheel events.
// ----------------------------------------------------------------------------
//  channel | dir | width | fields (lsb first)
//  req     | in  | 8     | midi_byte[7:0]
//  rsp     | out | 32    | event_kind[1:0] note_number[8:2] velocity[15:9]
//          |     |       | wheel_value[31:16]
//  csr     | in  | 4     | listen_channel (write only)
//
//  One byte per cycle while the queue has room; each byte yields one rsp beat via the queue and the output register.
//  The tracker updates state in the accept cycle; a small queue feeds the
//  output register, so req keeps flowing while a beat waits on rsp_tready.
//  req_tready drops only when the queue is full.
//  Synchronous active-high reset clears state, queue and output valid.
// ----------------------------------------------------------------------------
module midi_channel_message_parser
   import mcmp_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = QueueDepthDef
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [ByteWidth-1:0]    req_tdata,   // midi_byte
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [RspDataWidth-1:0] rsp_tdata,   // event_kind, note_number, velocity, wheel_value
   input  logic                    csr_we,
   input  logic [ChanWidth-1:0]    csr_wdata    // listen_channel
);

   logic [ChanWidth-1:0] listen_ff;
   logic                 accept;
   logic                 q_full;
   logic                 q_not_empty;
   logic                 q_pop;
   entry_type            f_entry;
   entry_type            q_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         listen_ff <= '0;
      end else if (csr_we) begin
         listen_ff <= csr_wdata;
      end
   end

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   mcmp_front u_front (
      .clock          (clock),
      .reset          (reset),
      .listen_channel (listen_ff),
      .accept         (accept),
      .midi_byte      (req_tdata),
      .entry          (f_entry)
   );

   mcmp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (f_entry),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_data  (q_data)
   );

   mcmp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_data      (q_data),
      .q_pop       (q_pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule
